// ===== rtl/u16u8_pkg.sv =====
// Shared types, constants and the UTF-8 encode function for the UTF-16LE to UTF-8 transcoder.
`default_nettype none

package u16u8_pkg;

  localparam int MAX_BYTES = 6;   // held 3-byte form plus up to 3 bytes of the new unit
  localparam int CNT_W     = 3;
  localparam int Q_DEPTH   = 2;

  localparam logic [15:0] HI_SURR_LO = 16'hd800;
  localparam logic [15:0] HI_SURR_HI = 16'hdbff;
  localparam logic [15:0] LO_SURR_LO = 16'hdc00;
  localparam logic [15:0] LO_SURR_HI = 16'hdfff;
  localparam logic [20:0] SUPP_BASE  = 21'h10000;

  localparam logic [20:0] MAX_ONE    = 21'h7f;
  localparam logic [20:0] MAX_TWO    = 21'h7ff;
  localparam logic [20:0] MAX_THREE  = 21'hffff;

  localparam logic [7:0]  LEAD_TWO   = 8'hc0;
  localparam logic [7:0]  LEAD_THREE = 8'he0;
  localparam logic [7:0]  LEAD_FOUR  = 8'hf0;
  localparam logic [7:0]  CONT_MARK  = 8'h80;
  localparam logic [7:0]  CONT_MASK  = 8'h3f;

  // up to four bytes of one code point
  typedef struct packed {
    logic [3:0][7:0]   bytes;
    logic [CNT_W-1:0]  count;
  } enc_t;

  // one queued job: the bytes caused by one accepted code unit
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [CNT_W-1:0]          count;   // 1..MAX_BYTES
    logic                      marker;  // bare end marker, no data byte
    logic                      ends;    // last byte closes the string
  } job_t;

  function automatic logic [7:0] cont_byte(input logic [5:0] bits);
    cont_byte = CONT_MARK | ({2'b00, bits} & CONT_MASK);
  endfunction

  function automatic enc_t utf8_encode(input logic [20:0] cp);
    enc_t e;
    e = '0;
    if (cp <= MAX_ONE) begin
      e.bytes[0] = cp[7:0];
      e.count    = CNT_W'(1);
    end else if (cp <= MAX_TWO) begin
      e.bytes[0] = LEAD_TWO | {3'b000, cp[10:6]};
      e.bytes[1] = cont_byte(cp[5:0]);
      e.count    = CNT_W'(2);
    end else if (cp <= MAX_THREE) begin
      e.bytes[0] = LEAD_THREE | {4'b0000, cp[15:12]};
      e.bytes[1] = cont_byte(cp[11:6]);
      e.bytes[2] = cont_byte(cp[5:0]);
      e.count    = CNT_W'(3);
    end else begin
      e.bytes[0] = LEAD_FOUR | {5'b00000, cp[20:18]};
      e.bytes[1] = cont_byte(cp[17:12]);
      e.bytes[2] = cont_byte(cp[11:6]);
      e.bytes[3] = cont_byte(cp[5:0]);
      e.count    = CNT_W'(4);
    end
    return e;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/u16u8_front.sv =====
// Front end: takes code units, tracks surrogate and discard state, builds byte jobs.
`default_nettype none

module u16u8_front
  import u16u8_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        accept,
  input  wire logic [15:0] code_unit,
  input  wire logic        last_unit,
  output      logic        job_push,
  output      job_t        job
);

  logic [9:0] held_bits, held_bits_next;
  logic       held_valid, held_valid_next;
  logic       discarding, discarding_next;

  logic is_low, is_high, is_zero;
  enc_t enc_pair, enc_held, enc_unit;

  assign is_low  = (code_unit >= LO_SURR_LO) && (code_unit <= LO_SURR_HI);
  assign is_high = (code_unit >= HI_SURR_LO) && (code_unit <= HI_SURR_HI);
  assign is_zero = (code_unit == 16'h0000);

  assign enc_pair = utf8_encode(SUPP_BASE + {1'b0, held_bits, code_unit[9:0]});
  assign enc_held = utf8_encode({5'b00000, HI_SURR_LO[15:10], held_bits});
  assign enc_unit = utf8_encode({5'b00000, code_unit});

  always_comb begin
    held_bits_next  = held_bits;
    held_valid_next = held_valid;
    discarding_next = discarding;
    job             = '0;
    job_push        = 1'b0;
    if (accept) begin
      if (discarding) begin
        if (last_unit) begin
          discarding_next = 1'b0;
        end
      end else if (held_valid && is_low) begin
        // surrogate pair -> 4 bytes
        held_valid_next = 1'b0;
        held_bits_next  = '0;
        job.bytes[3:0]  = enc_pair.bytes;
        job.count       = enc_pair.count;
        job.ends        = last_unit;
        job_push        = 1'b1;
      end else begin
        held_valid_next = 1'b0;
        held_bits_next  = '0;
        if (held_valid) begin
          job.bytes[2:0] = enc_held.bytes[2:0];
          job.count      = enc_held.count;
        end
        if (is_zero) begin
          job.ends        = 1'b1;
          discarding_next = !last_unit;
          if (!held_valid) begin
            job.marker = 1'b1;
            job.count  = CNT_W'(1);
          end
          job_push = 1'b1;
        end else if (is_high && !last_unit) begin
          held_bits_next  = code_unit[9:0];
          held_valid_next = 1'b1;
          job_push        = held_valid;
        end else begin
          job.ends = last_unit;
          if (held_valid) begin
            job.bytes[5:3] = enc_unit.bytes[2:0];
            job.count      = enc_held.count + enc_unit.count;
          end else begin
            job.bytes[3:0] = enc_unit.bytes;
            job.count      = enc_unit.count;
          end
          job_push = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_bits  <= '0;
      held_valid <= 1'b0;
      discarding <= 1'b0;
    end else begin
      held_bits  <= held_bits_next;
      held_valid <= held_valid_next;
      discarding <= discarding_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/u16u8_queue.sv =====
// Short job queue between the front end and the byte emitter.
`default_nettype none

module u16u8_queue
  import u16u8_pkg::*;
#(
  parameter int DEPTH = Q_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t wr_job,
  output      logic full,
  input  wire logic pop,
  output      job_t rd_job,
  output      logic empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_QW = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  job_t              slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_QW-1:0] fill;

  assign full   = (fill == CNT_QW'(DEPTH));
  assign empty  = (fill == '0);
  assign rd_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNT_QW'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_QW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/u16u8_back.sv =====
// Back end: walks the head job one byte per cycle into the result register, while that register is free or popped.
`default_nettype none

module u16u8_back
  import u16u8_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       q_empty,
  input  wire job_t       q_job,
  output      logic       q_pop,
  input  wire logic       pop,
  output      logic       empty,
  output      logic [7:0] out_byte,
  output      logic       byte_valid,
  output      logic       run_last,
  output      logic       string_end
);

  logic [CNT_W-1:0] idx;
  logic             res_valid;
  logic             load, at_last;

  assign load    = !q_empty && (!res_valid || pop);
  assign at_last = (idx == q_job.count - CNT_W'(1));
  assign q_pop   = load && at_last;
  assign empty   = !res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      res_valid <= 1'b0;
    end else begin
      if (load) begin
        res_valid <= 1'b1;
        idx       <= at_last ? '0 : idx + CNT_W'(1);
      end else if (pop) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte   <= q_job.marker ? 8'h00 : q_job.bytes[idx];
      byte_valid <= !q_job.marker;
      run_last   <= at_last;
      string_end <= at_last && q_job.ends;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/utf16le_to_utf8_transcoder_core.sv =====
// Top level of the UTF-16LE to UTF-8 transcoder: front end, job queue, byte emitter.
`default_nettype none

// Channel  | Handshake          | Payload
// ---------+--------------------+-----------------------------------------------
// input    | push / full        | code_unit[15:0], last_unit
// result   | empty / pop        | out_byte[7:0], byte_valid, run_last, string_end
//
// An input transaction is classified in the cycle it is accepted and turned into a job
// of 1..6 bytes, or none when a high surrogate is held or a unit is dropped. With the
// emitter free, the job is written to the queue and its first byte is then registered
// into the result register; then one byte per cycle while the result side pops, up to
// 6 for a broken pair plus a 3-byte unit. Reset (rst, synchronous) clears the
// surrogate/discard state, queue and result register; a full two-job queue holds input.
module utf16le_to_utf8_transcoder_core
  import u16u8_pkg::*;
#(
  parameter int QDEPTH = Q_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input queue side
  input  wire logic        push,
  output      logic        full,
  input  wire logic [15:0] code_unit,
  input  wire logic        last_unit,
  // result queue side
  input  wire logic        pop,
  output      logic        empty,
  output      logic [7:0]  out_byte,
  output      logic        byte_valid,
  output      logic        run_last,
  output      logic        string_end
);

  logic accept;
  logic job_push;
  job_t job_in;
  job_t job_head;
  logic q_full, q_empty, q_pop;

  // a transaction is taken whenever the queue has room
  assign full   = q_full;
  assign accept = push && !q_full;

  // classify the unit, hold high surrogates, drop units after a zero unit
  u16u8_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .code_unit (code_unit),
    .last_unit (last_unit),
    .job_push  (job_push),
    .job       (job_in)
  );

  // decouples classification from byte emission
  u16u8_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (job_push),
    .wr_job (job_in),
    .full   (q_full),
    .pop    (q_pop),
    .rd_job (job_head),
    .empty  (q_empty)
  );

  // one byte per cycle into the registered result, while it is free or popped
  u16u8_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_job      (job_head),
    .q_pop      (q_pop),
    .pop        (pop),
    .empty      (empty),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .run_last   (run_last),
    .string_end (string_end)
  );

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the UTF-16LE to UTF-8 transcoder core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Surrogate ranges and the supplementary plane base
  localparam logic [15:0] HIGH_FIRST  = 16'hd800;
  localparam logic [15:0] HIGH_LAST   = 16'hdbff;
  localparam logic [15:0] LOW_FIRST   = 16'hdc00;
  localparam logic [15:0] LOW_LAST    = 16'hdfff;
  localparam logic [20:0] SUPP_OFFSET = 21'h10000;
  // UTF-8 range limits and byte marks
  localparam logic [20:0] ONE_BYTE_MAX   = 21'h7f;
  localparam logic [20:0] TWO_BYTE_MAX   = 21'h7ff;
  localparam logic [20:0] THREE_BYTE_MAX = 21'hffff;
  localparam logic [7:0]  LEAD2 = 8'hc0;
  localparam logic [7:0]  LEAD3 = 8'he0;
  localparam logic [7:0]  LEAD4 = 8'hf0;
  localparam logic [7:0]  CONT  = 8'h80;

  localparam int RESET_CYCLES = 12;
  localparam int SETTLE_CYCLES = 24;     // quiet time after the last expected byte
  localparam int CYCLE_LIMIT = 400000;   // far beyond the slowest legal run

  // One expected UTF-8 result transaction
  typedef struct packed {
    logic [7:0] value;
    logic       valid;
    logic       run_last;
    logic       string_end;
  } utf8_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic [15:0] code_unit = '0;
  logic        last_unit = 1'b0;
  logic        pop = 1'b0;
  logic        full;
  logic        empty;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        run_last;
  logic        string_end;

  utf8_byte_t utf8_expected[$];  // bytes still owed by the DUT, oldest first
  utf8_byte_t unit_bytes[$];     // scratch: bytes caused by the unit being predicted

  // Predictor state, mirrors the transcoder's surrogate/discard state
  logic [9:0]  held_bits = '0;
  logic        held_valid = 1'b0;
  logic        discard_active = 1'b0;

  int          mismatch_count = 0;
  int          units_fed = 0;       // units that were not swallowed by discarding
  int          burst_left = 0;
  int          cycle_count = 0;
  logic [15:0] pop_pattern = 16'hffff;
  int          pattern_age = 0;

  utf16le_to_utf8_transcoder_core dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .code_unit  (code_unit),
    .last_unit  (last_unit),
    .pop        (pop),
    .empty      (empty),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .run_last   (run_last),
    .string_end (string_end)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  task automatic add_byte(input logic [7:0] value, input logic valid);
    utf8_byte_t b;
    b = '{value: value, valid: valid, run_last: 1'b0, string_end: 1'b0};
    unit_bytes = {unit_bytes, b};
  endtask

  // Standard UTF-8 encoding of one code point, 1 to 4 bytes
  task automatic encode_code_point(input logic [20:0] cp);
    if (cp <= ONE_BYTE_MAX) begin
      add_byte(cp[7:0], 1'b1);
    end else if (cp <= TWO_BYTE_MAX) begin
      add_byte(LEAD2 | {3'b000, cp[10:6]}, 1'b1);
      add_byte(CONT | {2'b00, cp[5:0]}, 1'b1);
    end else if (cp <= THREE_BYTE_MAX) begin
      add_byte(LEAD3 | {4'b0000, cp[15:12]}, 1'b1);
      add_byte(CONT | {2'b00, cp[11:6]}, 1'b1);
      add_byte(CONT | {2'b00, cp[5:0]}, 1'b1);
    end else begin
      add_byte(LEAD4 | {5'b00000, cp[20:18]}, 1'b1);
      add_byte(CONT | {2'b00, cp[17:12]}, 1'b1);
      add_byte(CONT | {2'b00, cp[11:6]}, 1'b1);
      add_byte(CONT | {2'b00, cp[5:0]}, 1'b1);
    end
  endtask

  // Works out the bytes one accepted code unit causes and queues them
  task automatic transcode_unit(input logic [15:0] unit, input logic last);
    logic ends;
    logic paired;
    ends = 1'b0;
    paired = 1'b0;
    unit_bytes.delete();
    // after a zero unit everything up to the last flag is dropped silently
    if (discard_active) begin
      if (last) discard_active = 1'b0;
      return;
    end
    if (held_valid) begin
      held_valid = 1'b0;
      if (unit >= LOW_FIRST && unit <= LOW_LAST) begin
        encode_code_point(SUPP_OFFSET + (21'(held_bits) << 10) + 21'(unit - LOW_FIRST));
        ends = last;
        paired = 1'b1;
      end else begin
        // broken pair: held high surrogate goes out as its own 3-byte form
        encode_code_point(21'(HIGH_FIRST | {6'b000000, held_bits}));
      end
      held_bits = '0;
    end
    if (!paired) begin
      if (unit == 16'h0000) begin
        ends = 1'b1;
        if (!last) discard_active = 1'b1;
        if (unit_bytes.size() == 0) add_byte(8'h00, 1'b0);  // bare end marker
      end else if (unit >= HIGH_FIRST && unit <= HIGH_LAST && !last) begin
        held_bits = unit[9:0];
        held_valid = 1'b1;
      end else begin
        encode_code_point(21'(unit));
        ends = last;
      end
    end
    if (unit_bytes.size() > 0) begin
      unit_bytes[unit_bytes.size()-1].run_last = 1'b1;
      unit_bytes[unit_bytes.size()-1].string_end = ends;
      utf8_expected = {utf8_expected, unit_bytes};
    end
  endtask

  // ---------------------------------------------------------------------------
  // Input side: bursty sender
  // ---------------------------------------------------------------------------
  // Always entered right after a rising edge. push is only lowered when a real
  // gap follows, so a back-to-back transaction never sees push dropped and
  // raised in the same step.
  task automatic send_unit(input logic [15:0] unit, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      burst_left = (gap == 0) ? $urandom_range(16, 40) : $urandom_range(1, 10);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    push      <= 1'b1;
    code_unit <= unit;
    last_unit <= last;
    do @(posedge clk); while (full);
    if (!discard_active) units_fed++;
    transcode_unit(unit, last);
  endtask

  // Hold input off until every owed byte has been popped
  task automatic wait_for_drain();
    push <= 1'b0;
    @(posedge clk);
    while (utf8_expected.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: stall pattern and checker
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what);
    $display("ERROR @%0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : result_check
    utf8_byte_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (utf8_expected.size() == 0) begin
          report_mismatch($sformatf("unexpected result transaction, byte %h", out_byte));
        end else begin
          want = utf8_expected.pop_front();
          if (out_byte !== want.value)
            report_mismatch($sformatf("out_byte %h, expected %h", out_byte, want.value));
          if (byte_valid !== want.valid)
            report_mismatch($sformatf("byte_valid %b, expected %b", byte_valid, want.valid));
          if (run_last !== want.run_last)
            report_mismatch($sformatf("run_last %b, expected %b", run_last, want.run_last));
          if (string_end !== want.string_end)
            report_mismatch($sformatf("string_end %b, expected %b", string_end,
                                      want.string_end));
        end
      end
      // new stall pattern whenever pattern_age wraps: free-running, random, or long stalls
      if (pattern_age == 47) begin
        pattern_age <= 0;
        case ($urandom_range(0, 3))
          0:       pop_pattern <= 16'hffff;
          1:       pop_pattern <= 16'h0101;
          default: pop_pattern <= 16'($urandom);
        endcase
      end else begin
        pattern_age <= pattern_age + 1;
        pop_pattern <= {pop_pattern[0], pop_pattern[15:1]};
      end
      pop <= pop_pattern[0];
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL utf16le_to_utf8_transcoder_core");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // 1-, 2- and 3-byte range edges; last flag closes the string
  task automatic test_encoding_widths();
    send_unit(16'h0001, 1'b0);
    send_unit(16'h007f, 1'b0);
    send_unit(16'h0080, 1'b0);
    send_unit(16'h07ff, 1'b0);
    send_unit(16'h0800, 1'b0);
    send_unit(16'hffff, 1'b1);
  endtask

  task automatic test_surrogates();
    send_unit(16'hd800, 1'b0);  // lowest pair
    send_unit(16'hdc00, 1'b0);
    send_unit(16'hdbff, 1'b0);  // highest pair, ends the string
    send_unit(16'hdfff, 1'b1);
    send_unit(16'hdc00, 1'b0);  // lone low surrogate
    send_unit(16'hd812, 1'b0);  // high followed by plain unit
    send_unit(16'h0041, 1'b0);
    send_unit(16'hd801, 1'b0);  // high followed by high, then a low pairs up
    send_unit(16'hd802, 1'b0);
    send_unit(16'hdc05, 1'b0);
    send_unit(16'hdbff, 1'b1);  // high surrogate as final unit
  endtask

  task automatic test_zero_unit();
    send_unit(16'hd8aa, 1'b0);  // held high then zero: held bytes carry the end
    send_unit(16'h0000, 1'b0);
    send_unit(16'h0041, 1'b0);  // dropped
    send_unit(16'hd800, 1'b0);  // dropped
    send_unit(16'h0000, 1'b1);  // dropped, leaves discarding
    send_unit(16'h0000, 1'b1);  // bare marker
    send_unit(16'h0000, 1'b0);  // bare marker, starts discarding
    send_unit(16'hffff, 1'b1);  // dropped, leaves discarding
    send_unit(16'h007e, 1'b1);
  endtask

  function automatic logic [15:0] random_bmp_unit();
    if ($urandom_range(0, 1) == 0) return 16'($urandom_range(16'h0800, 16'hd7ff));
    return 16'($urandom_range(16'he000, 16'hffff));
  endfunction

  // Mostly well-formed strings with random content, some raw noise
  task automatic test_random_strings(input int target);
    logic [15:0] str_units[$];
    int len;
    while (units_fed < target) begin
      if ($urandom_range(0, 9) < 2) begin
        send_unit(16'($urandom), 1'($urandom_range(0, 1)));
      end else begin
        str_units.delete();
        len = $urandom_range(1, 8);
        repeat (len) begin
          case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5: str_units = {str_units, 16'($urandom_range(1, 16'h7f))};
            6, 7, 8:          str_units = {str_units, 16'($urandom_range(16'h80, 16'h7ff))};
            9, 10, 11, 12:    str_units = {str_units, random_bmp_unit()};
            13, 14, 15, 16: begin
              str_units = {str_units, 16'($urandom_range(HIGH_FIRST, HIGH_LAST))};
              str_units = {str_units, 16'($urandom_range(LOW_FIRST, LOW_LAST))};
            end
            17: str_units = {str_units, 16'($urandom_range(HIGH_FIRST, HIGH_LAST))};
            18: str_units = {str_units, 16'($urandom_range(LOW_FIRST, LOW_LAST))};
            default: str_units = {str_units, 16'h0000};
          endcase
        end
        foreach (str_units[i]) send_unit(str_units[i], i == str_units.size() - 1);
      end
    end
  endtask

  // Let the result side run dry mid-stream, then carry on
  task automatic test_drain_pause();
    wait_for_drain();
    send_unit(16'hd83d, 1'b0);
    send_unit(16'hde00, 1'b1);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_encoding_widths();
    test_surrogates();
    test_zero_unit();
    test_random_strings(units_fed + 100);
    test_drain_pause();
    test_random_strings(units_fed + 105);
    // drain, then give stray results a chance to show up
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && utf8_expected.size() == 0) begin
      $display("PASS utf16le_to_utf8_transcoder_core");
    end else begin
      $display("FAIL utf16le_to_utf8_transcoder_core");
    end
    $finish;
  end

endmodule
